/* rtl/core/mipm_pkg.sv */
// ============================================================================
// mipm_pkg
// Shared types and codes for the interest point marker core.
// ============================================================================
`default_nettype none

package mipm_pkg;

    // Field widths fixed by the interface
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int DIM_W      = 9;
    localparam int HALF_W     = 4;
    localparam int THR_W      = 16;
    localparam int MEAS_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd3;

    // Evaluation centres: the pixel itself, then its 4-neighbours
    localparam logic [2:0] EV_CENTRE = 3'd0;
    localparam logic [2:0] EV_LEFT   = 3'd1;
    localparam logic [2:0] EV_RIGHT  = 3'd2;
    localparam logic [2:0] EV_UP     = 3'd3;
    localparam logic [2:0] EV_DOWN   = 3'd4;

    // Read phases within one window position
    localparam logic [2:0] PH_CENTRE = 3'd0;
    localparam logic [2:0] PH_RIGHT  = 3'd1;
    localparam logic [2:0] PH_DOWN   = 3'd2;
    localparam logic [2:0] PH_DR     = 3'd3;
    localparam logic [2:0] PH_UR     = 3'd4;
    localparam logic [2:0] PH_LAST   = 3'd5;

    // Last direction index of the minimum pass
    localparam logic [1:0] DIR_LAST = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_CELL  = 6'b000100,
        S_MIN   = 6'b001000,
        S_JUDGE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/mipm_ram.sv */
// ============================================================================
// mipm_ram
// Generic single-port RAM with registered read data.
// ============================================================================
`default_nettype none

module mipm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* rtl/core/moravec_interest_point_marker_core.sv */
// ============================================================================
// moravec_interest_point_marker_core
// Frame store with a Moravec-style interest measure and corner cross marker.
// ============================================================================
// Usage:
//  - Command channel: a transaction is taken when start is high and busy is
//    low. operation selects a pixel write or an interest query at
//    (column, row). Every transaction gives exactly one result.
//  - Result: presented for one cycle with done high; the receiver cannot
//    stall, so the result must be captured in that cycle.
//  - Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//    width, height, half window or threshold. cfg_ready is always high;
//    write only while busy is low.
//  - Sequence: a write, an out-of-frame query or a query with k = 0 goes
//    from accept straight to the result state. A query runs one to five
//    window evaluations (the pixel, then each in-image 4-neighbour until a
//    corner is found). An evaluation has a setup step, reads each in-image
//    window position, skips each out-of-image one, then runs the minimum
//    search and the decision.
//  - The query time is set by the frame store's single read port: five reads
//    per window position, one per cycle, through one shared accumulator.
//  - Reset: registers return to 256 x 256, k = 1, threshold 1000. The frame
//    store is not cleared; every pixel must be written before queries.
// ============================================================================
`default_nettype none

module moravec_interest_point_marker_core #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int MAX_HALF_WINDOW = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            operation,
    input  wire logic [mipm_pkg::COORD_W-1:0]    column,
    input  wire logic [mipm_pkg::COORD_W-1:0]    row,
    input  wire logic [mipm_pkg::PIX_W-1:0]      gray_level,
    // result
    output logic                                 done,
    output logic [mipm_pkg::MEAS_W-1:0]          interest_measure,
    output logic                                 is_corner,
    output logic                                 is_marked,
    output logic                                 bad_coordinate,
    // configuration channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mipm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mipm_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mipm_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int MAXDIM0 = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int MAXDIM  = (MAXDIM0 > 256) ? MAXDIM0 : 256;
    // signed coordinate width: covers image, window overhang and neighbours
    localparam int CW      = $clog2(MAXDIM + 2 * MAX_HALF_WINDOW + 2) + 1;
    // directional sum: at most (2k)^2 terms of magnitude 255
    localparam int SW      = $clog2((2 * MAX_HALF_WINDOW) * (2 * MAX_HALF_WINDOW) * 255 + 1)
                             + 1;
    localparam int MW      = (SW > MEAS_W) ? SW : MEAS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [HALF_W-1:0] half_reg;
    logic [THR_W-1:0]  thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            half_reg   <= HALF_W'(1);
            thr_reg    <= THR_W'(1000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_WINDOW_HALF:  half_reg   <= cfg_data[HALF_W-1:0];
                CFG_THRESHOLD:    thr_reg    <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective (clamped) frame size and half window
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] h_s;
    logic signed [CW-1:0] k_s;

    always_comb
    begin
        if (width_reg == '0)
            w_s = CW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_s = CW'(MAX_WIDTH);
        else
            w_s = CW'(width_reg);

        if (height_reg == '0)
            h_s = CW'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_s = CW'(MAX_HEIGHT);
        else
            h_s = CW'(height_reg);

        if (int'(half_reg) > MAX_HALF_WINDOW)
            k_s = CW'(MAX_HALF_WINDOW);
        else
            k_s = CW'(half_reg);
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t                      state_reg,  state_next;
    logic signed [CW-1:0]        x_reg,      x_next;
    logic signed [CW-1:0]        y_reg,      y_next;
    logic [2:0]                  eval_reg,   eval_next;
    logic signed [CW-1:0]        i_reg,      i_next;
    logic signed [CW-1:0]        j_reg,      j_next;
    logic [2:0]                  phase_reg,  phase_next;
    logic [1:0]                  dir_reg,    dir_next;
    logic [PIX_W-1:0]            c_reg,      c_next;
    logic signed [SW-1:0]        sum_reg  [4];
    logic signed [SW-1:0]        sum_next [4];
    logic [MW-1:0]               m_reg,      m_next;
    logic [MEAS_W-1:0]           meas_reg,   meas_next;
    logic                        corner_reg, corner_next;
    logic                        marked_reg, marked_next;
    logic                        bad_reg,    bad_next;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                 accept;
    logic signed [CW-1:0] col_s;
    logic signed [CW-1:0] row_s;
    logic                 bad_in;

    assign accept = start && !busy;
    assign col_s  = CW'(column);
    assign row_s  = CW'(row);
    assign bad_in = (col_s >= w_s) || (row_s >= h_s);

    // ------------------------------------------------------------------
    // Evaluation centre, window cell and read point
    // ------------------------------------------------------------------
    logic signed [CW-1:0] ex, ey;     // evaluation centre
    logic signed [CW-1:0] cx, cy;     // window cell
    logic signed [CW-1:0] px, py;     // point being read
    logic                 centre_in;
    logic                 cell_in;
    logic [3:0]           nb_ok;      // right, down, down-right, up-right

    always_comb
    begin
        ex = x_reg;
        ey = y_reg;
        case (eval_reg)
            EV_LEFT:  ex = x_reg - CW'(1);
            EV_RIGHT: ex = x_reg + CW'(1);
            EV_UP:    ey = y_reg - CW'(1);
            EV_DOWN:  ey = y_reg + CW'(1);
            default:  ;
        endcase
    end

    assign centre_in = (ex >= 0) && (ey >= 0) && (ex < w_s) && (ey < h_s);
    assign cx        = ex + i_reg;
    assign cy        = ey + j_reg;
    assign cell_in   = (cx >= 0) && (cy >= 0) && (cx < w_s) && (cy < h_s);

    assign nb_ok[0] = (cx + CW'(1)) < w_s;
    assign nb_ok[1] = (cy + CW'(1)) < h_s;
    assign nb_ok[2] = nb_ok[0] && nb_ok[1];
    assign nb_ok[3] = (cy >= CW'(1)) && nb_ok[0];

    always_comb
    begin
        px = cx;
        py = cy;
        case (phase_reg)
            PH_RIGHT: px = cx + CW'(1);
            PH_DOWN:  py = cy + CW'(1);
            PH_DR:
            begin
                px = cx + CW'(1);
                py = cy + CW'(1);
            end
            PH_UR:
            begin
                px = cx + CW'(1);
                py = cy - CW'(1);
            end
            default:  ;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame store
    // ------------------------------------------------------------------
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    ram_addr;
    logic             ram_we;
    logic [PIX_W-1:0] ram_rdata;

    assign wr_addr  = AW'(row) * AW'(MAX_WIDTH) + AW'(column);
    assign rd_addr  = AW'($unsigned(py)) * AW'(MAX_WIDTH) + AW'($unsigned(px));
    assign ram_addr = busy ? rd_addr : wr_addr;
    assign ram_we   = accept && (operation == OP_WRITE) && !bad_in;

    mipm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (gray_level),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared accumulator: sum[d] += pixel - centre
    // Read data arrives in the cycle after its address, so phase p sees point p-1.
    // ------------------------------------------------------------------
    logic signed [PIX_W:0] diff;
    logic [1:0]            acc_sel;
    logic signed [SW-1:0]  acc_sum;

    assign diff    = $signed({1'b0, ram_rdata}) - $signed({1'b0, c_reg});
    assign acc_sel = 2'(phase_reg - PH_DOWN);
    assign acc_sum = sum_reg[acc_sel] + SW'(diff);

    // Shared magnitude / compare unit for the minimum pass
    logic signed [SW-1:0] dir_sum;
    logic [MW-1:0]        dir_abs;

    assign dir_sum = sum_reg[dir_reg];
    assign dir_abs = dir_sum[SW-1] ? MW'($unsigned(-dir_sum)) : MW'($unsigned(dir_sum));

    logic m_hot;
    assign m_hot = m_reg > MW'(thr_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic last_cell;
    assign last_cell = (i_reg == k_s - CW'(1)) && (j_reg == k_s - CW'(1));

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        eval_next   = eval_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        c_next      = c_reg;
        sum_next    = sum_reg;
        m_next      = m_reg;
        meas_next   = meas_reg;
        corner_next = corner_reg;
        marked_next = marked_reg;
        bad_next    = bad_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next      = col_s;
                    y_next      = row_s;
                    bad_next    = bad_in;
                    meas_next   = '0;
                    corner_next = 1'b0;
                    marked_next = 1'b0;
                    eval_next   = EV_CENTRE;
                    if ((operation == OP_WRITE) || bad_in || (k_s == '0))
                        state_next = S_DONE;
                    else
                        state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (centre_in)
                begin
                    i_next     = -k_s;
                    j_next     = -k_s;
                    phase_next = PH_CENTRE;
                    for (int d = 0; d < 4; d++)
                        sum_next[d] = '0;
                    state_next = S_CELL;
                end
                else if (eval_reg == EV_DOWN)
                    state_next = S_DONE;
                else
                    eval_next = eval_reg + 3'd1;
            end

            S_CELL:
            begin
                if (phase_reg == PH_RIGHT)
                    c_next = ram_rdata;
                else if ((phase_reg != PH_CENTRE) && nb_ok[acc_sel])
                    sum_next[acc_sel] = acc_sum;

                if (((phase_reg == PH_CENTRE) && !cell_in) || (phase_reg == PH_LAST))
                begin
                    // next window position
                    phase_next = PH_CENTRE;
                    if (last_cell)
                    begin
                        dir_next   = '0;
                        state_next = S_MIN;
                    end
                    else if (j_reg == k_s - CW'(1))
                    begin
                        j_next = -k_s;
                        i_next = i_reg + CW'(1);
                    end
                    else
                        j_next = j_reg + CW'(1);
                end
                else
                    phase_next = phase_reg + 3'd1;
            end

            S_MIN:
            begin
                if ((dir_reg == '0) || (dir_abs < m_reg))
                    m_next = dir_abs;
                dir_next = dir_reg + 2'd1;
                if (dir_reg == DIR_LAST)
                    state_next = S_JUDGE;
            end

            S_JUDGE:
            begin
                if (eval_reg == EV_CENTRE)
                begin
                    meas_next   = m_reg[MEAS_W-1:0];
                    corner_next = m_hot;
                end
                if (m_hot)
                    marked_next = 1'b1;
                if (m_hot || (eval_reg == EV_DOWN))
                    state_next = S_DONE;
                else
                begin
                    eval_next  = eval_reg + 3'd1;
                    state_next = S_EVAL;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            eval_reg   <= EV_CENTRE;
            phase_reg  <= PH_CENTRE;
            dir_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            eval_reg   <= eval_next;
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        c_reg      <= c_next;
        sum_reg    <= sum_next;
        m_reg      <= m_next;
        meas_reg   <= meas_next;
        corner_reg <= corner_next;
        marked_reg <= marked_next;
        bad_reg    <= bad_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy             = (state_reg != S_IDLE);
    assign done             = (state_reg == S_DONE);
    assign interest_measure = meas_reg;
    assign is_corner        = corner_reg;
    assign is_marked        = marked_reg;
    assign bad_coordinate   = bad_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the Moravec-style interest point marker core.
// Loads small gray frames pixel by pixel and queries the interest measure,
// the corner flag and the cross marking. Each result is checked against a
// behavioural predictor with its own frame and register copies or a result
// typed into the table. A short table of directed transactions runs first,
// followed by randomised frame phases with random sender gaps.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    import mipm_pkg::*;

    localparam int FRAME_MAX_W  = 256;
    localparam int FRAME_MAX_H  = 256;
    localparam int HALF_MAX     = 8;
    localparam int ITEM_TARGET  = 445;      // the last phase runs to its end, so the total can exceed this
    localparam int REPORT_LIMIT = 10;
    localparam int TAIL_CYCLES  = 32;
    localparam int RUN_LIMIT_NS = 60_000_000;

    // One result as it appears on the result ports
    typedef struct packed {
        logic [MEAS_W-1:0] measure;
        logic              corner;
        logic              marked;
        logic              bad;
    } marker_result_t;

    localparam marker_result_t RES_CLEAR = '0;
    localparam marker_result_t RES_BAD   = '{16'd0, 1'b0, 1'b0, 1'b1};

    // Directed table: a register write, an item checked against the
    // predictor, or an item whose result is typed in
    typedef enum logic [1:0] {
        VEC_REG,
        VEC_ITEM,
        VEC_FIXED
    } vec_kind_t;

    typedef struct packed {
        vec_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic                   op;
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [PIX_W-1:0]       gray;
        marker_result_t         res;
    } vector_t;

    localparam int N_STEPS = 38;

    vector_t directed_steps [N_STEPS] = '{
        // reset defaults: 256 x 256, k = 1, threshold 1000
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd0,   8'd0,   8'd0,   RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd255, 8'd255, 8'd255, RES_CLEAR},
        // zero window: queries read nothing and report zero anywhere
        '{VEC_REG, CFG_WINDOW_HALF, 16'd0, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd255, 8'd255, 8'd0,   RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd0,   8'd0,   8'd255, RES_CLEAR},
        // coordinate check against a 200 x 100 frame
        '{VEC_REG, CFG_IMAGE_WIDTH,  16'd200, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_IMAGE_HEIGHT, 16'd100, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd200, 8'd5,   8'd9,   RES_BAD},
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd17,  8'd100, 8'd0,   RES_BAD},
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd255, 8'd255, 8'd0,   RES_BAD},
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd199, 8'd99,  8'd77,  RES_CLEAR},
        // width 0 acts as 1, upper bits dropped, k of 15 saturates to 8
        '{VEC_REG, CFG_IMAGE_WIDTH,  16'hFE00, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_IMAGE_HEIGHT, 16'hFE01, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_WINDOW_HALF,  16'hFFFF, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_THRESHOLD,    16'd0,    '0, '0, '0, '0, RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd0,   8'd0,   8'd200, RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd1,   8'd0,   8'd3,   RES_BAD},
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd0,   8'd1,   8'd3,   RES_BAD},
        // single pixel: every sum is zero, and zero does not exceed zero
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd0,   8'd0,   8'd0,   RES_CLEAR},
        // 2 x 2 checkerboard with threshold 0
        '{VEC_REG, CFG_IMAGE_WIDTH,  16'd2, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_IMAGE_HEIGHT, 16'd2, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_WINDOW_HALF,  16'd1, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_WRITE, 8'd0, 8'd0, 8'd0,   RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_WRITE, 8'd1, 8'd0, 8'd255, RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_WRITE, 8'd0, 8'd1, 8'd255, RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_WRITE, 8'd1, 8'd1, 8'd0,   RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0,   RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_QUERY, 8'd1, 8'd1, 8'd0,   RES_CLEAR},
        // top threshold and the widest window
        '{VEC_REG, CFG_THRESHOLD,   16'hFFFF, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_WINDOW_HALF, 16'd8,    '0, '0, '0, '0, RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_QUERY, 8'd1, 8'd0, 8'd0,   RES_CLEAR},
        '{VEC_ITEM, '0, '0, OP_QUERY, 8'd0, 8'd1, 8'd0,   RES_CLEAR},
        // width 511 saturates to 256; last column with k = 0
        '{VEC_REG, CFG_IMAGE_WIDTH, 16'h01FF, '0, '0, '0, '0, RES_CLEAR},
        '{VEC_REG, CFG_WINDOW_HALF, 16'd0,    '0, '0, '0, '0, RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_WRITE, 8'd255, 8'd1, 8'hA5, RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd255, 8'd1, 8'd0,  RES_CLEAR},
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd255, 8'd2, 8'd0,  RES_BAD},
        '{VEC_FIXED, '0, '0, OP_QUERY, 8'd0,   8'd0, 8'h5A, RES_CLEAR}
    };

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  operation;
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic [PIX_W-1:0]      gray_level;
    logic                  done;
    logic [MEAS_W-1:0]     interest_measure;
    logic                  is_corner;
    logic                  is_marked;
    logic                  bad_coordinate;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    moravec_interest_point_marker_core #(
        .MAX_WIDTH       (FRAME_MAX_W),
        .MAX_HEIGHT      (FRAME_MAX_H),
        .MAX_HALF_WINDOW (HALF_MAX)
    ) u_dut (
        .*
    );

    // ------------------------------------------------------------------------
    // Predictor state: shadow frame and register copies (reset values)
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0]  shadow_frame [FRAME_MAX_W * FRAME_MAX_H];
    logic [DIM_W-1:0]  reg_width  = 9'd256;
    logic [DIM_W-1:0]  reg_height = 9'd256;
    logic [HALF_W-1:0] reg_half   = 4'd1;
    logic [THR_W-1:0]  reg_thr    = 16'd1000;

    marker_result_t marking_due [$];   // results still owed, oldest first
    int             items_sent  = 0;
    int             fault_count = 0;
    bit             steady_sender = 1'b0;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int pel(input int x, input int y);
        return int'(shadow_frame[y * FRAME_MAX_W + x]);
    endfunction

    // Minimum of the four absolute directional sums over the window whose
    // offsets run from -k to k-1 in both axes; off-frame centres and
    // off-frame neighbours simply drop out of the sums.
    function automatic int interest_at(input int x, input int y, input int w,
                                       input int h, input int k);
        int s_r, s_d, s_dr, s_ur, i, j, cx, cy, c, m;
        s_r  = 0;
        s_d  = 0;
        s_dr = 0;
        s_ur = 0;
        for (i = -k; i < k; i++)
        begin
            for (j = -k; j < k; j++)
            begin
                cx = x + i;
                cy = y + j;
                if (cx >= 0 && cy >= 0 && cx < w && cy < h)
                begin
                    c = pel(cx, cy);
                    if (cx + 1 < w)
                        s_r += pel(cx + 1, cy) - c;
                    if (cy + 1 < h)
                        s_d += pel(cx, cy + 1) - c;
                    if (cx + 1 < w && cy + 1 < h)
                        s_dr += pel(cx + 1, cy + 1) - c;
                    if (cy >= 1 && cx + 1 < w)
                        s_ur += pel(cx + 1, cy - 1) - c;
                end
            end
        end
        s_r  = (s_r  < 0) ? -s_r  : s_r;
        s_d  = (s_d  < 0) ? -s_d  : s_d;
        s_dr = (s_dr < 0) ? -s_dr : s_dr;
        s_ur = (s_ur < 0) ? -s_ur : s_ur;
        m = s_r;
        if (s_d < m)
            m = s_d;
        if (s_dr < m)
            m = s_dr;
        if (s_ur < m)
            m = s_ur;
        return m;
    endfunction

    // Result of one accepted transaction; writes land in the shadow frame
    function automatic marker_result_t compute_marking(input logic op,
                                                       input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y,
                                                       input logic [PIX_W-1:0] gray);
        marker_result_t r;
        int w, h, k, m, xi, yi;
        w  = (reg_width == 0) ? 1 :
             (reg_width > FRAME_MAX_W) ? FRAME_MAX_W : int'(reg_width);
        h  = (reg_height == 0) ? 1 :
             (reg_height > FRAME_MAX_H) ? FRAME_MAX_H : int'(reg_height);
        k  = (reg_half > HALF_MAX) ? HALF_MAX : int'(reg_half);
        xi = x;
        yi = y;
        r  = RES_CLEAR;
        r.bad = (xi >= w) || (yi >= h);
        if (op == OP_WRITE)
        begin
            if (!r.bad)
                shadow_frame[yi * FRAME_MAX_W + xi] = gray;
        end
        else if (!r.bad && k > 0)
        begin
            m = interest_at(xi, yi, w, h, k);
            r.measure = m[MEAS_W-1:0];
            r.corner  = (m > reg_thr);
            r.marked  = r.corner;
            // the cross: any in-frame 4-neighbour that is itself a corner
            if (!r.marked && xi > 0 && interest_at(xi - 1, yi, w, h, k) > reg_thr)
                r.marked = 1'b1;
            if (!r.marked && xi + 1 < w && interest_at(xi + 1, yi, w, h, k) > reg_thr)
                r.marked = 1'b1;
            if (!r.marked && yi > 0 && interest_at(xi, yi - 1, w, h, k) > reg_thr)
                r.marked = 1'b1;
            if (!r.marked && yi + 1 < h && interest_at(xi, yi + 1, w, h, k) > reg_thr)
                r.marked = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    function automatic int next_gap();
        return steady_sender ? 0 : int'($urandom_range(0, 14));
    endfunction

    // Holds start low once, then waits until every owed result has come in
    // and the core has dropped busy. Ends on a falling edge.
    task automatic wait_all_results();
        @(negedge clk);
        start <= 1'b0;
        while (marking_due.size() != 0 || busy)
            @(negedge clk);
    endtask

    // One command transaction. start stays high into the next transaction
    // when there is no gap, so it is never dropped and raised in one step.
    task automatic send_item(input logic op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] gray,
                             input bit use_fixed, input marker_result_t fixed_res,
                             input int gap);
        marker_result_t due;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        operation  <= op;
        column     <= x;
        row        <= y;
        gray_level <= gray;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        due = compute_marking(op, x, y, gray);
        if (use_fixed)
            due = fixed_res;
        marking_due.push_back(due);
        items_sent++;
        // now and then let the core run dry before the next transaction
        if ($urandom_range(0, 39) == 0)
            wait_all_results();
    endtask

    // An out-of-frame transaction of either kind; never touches the store
    task automatic send_stray(input int w, input int h);
        int x, y;
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
        if (x < w && y < h)
            x = $urandom_range(w, 255);
        send_item($urandom_range(0, 1) ? OP_QUERY : OP_WRITE, 8'(x), 8'(y),
                  8'($urandom), 1'b0, RES_CLEAR, next_gap());
    endtask

    // Register write, only ever with the core idle and nothing owed
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width  = value[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: reg_height = value[DIM_W-1:0];
            CFG_WINDOW_HALF:  reg_half   = value[HALF_W-1:0];
            CFG_THRESHOLD:    reg_thr    = value[THR_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checking: every done cycle is one transaction, sampled on the
    // rising edge that closes it, against the oldest owed result
    // ------------------------------------------------------------------------
    function automatic void log_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, what);
    endfunction

    always @(posedge clk)
    begin
        marker_result_t seen, want;
        if (rst_n && done)
        begin
            seen = '{interest_measure, is_corner, is_marked, bad_coordinate};
            if (marking_due.size() == 0)
            begin
                log_fault($sformatf("result with nothing owed: measure %0d c%b m%b b%b",
                                    seen.measure, seen.corner, seen.marked, seen.bad));
            end
            else
            begin
                want = marking_due.pop_front();
                if (seen.measure !== want.measure || seen.corner !== want.corner ||
                    seen.marked !== want.marked || seen.bad !== want.bad)
                begin
                    log_fault($sformatf({"mismatch (exp/got): measure %0d/%0d ",
                                         "corner %b/%b marked %b/%b bad %b/%b"},
                                        want.measure, seen.measure, want.corner,
                                        seen.corner, want.marked, seen.marked,
                                        want.bad, seen.bad));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int          w, h, k, thr, n_q, style, pick, x, y, n;
        logic [15:0] junk;
        logic [7:0]  shade;

        // every input known from time zero; reset held low, then released on a falling edge
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = OP_WRITE;
        column     = '0;
        row        = '0;
        gray_level = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_IMAGE_WIDTH;
        cfg_data   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (n = 0; n < N_STEPS; n++)
        begin
            case (directed_steps[n].kind)
                VEC_REG:
                    write_register(directed_steps[n].reg_idx, directed_steps[n].reg_val);
                default:
                    send_item(directed_steps[n].op, directed_steps[n].x, directed_steps[n].y,
                              directed_steps[n].gray, directed_steps[n].kind == VEC_FIXED,
                              directed_steps[n].res, next_gap());
            endcase
        end

        // Random phases. Each phase sets up a small frame, loads every pixel
        // of it (with stray out-of-frame transactions mixed in) and only then
        // queries, so no query ever reads a pixel that was never written.
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    w = 1;
                    h = $urandom_range(1, 4);
                end
                1:
                begin
                    w = $urandom_range(20, 40);
                    h = $urandom_range(1, 2);
                end
                2:
                begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(10, 24);
                end
                default:
                begin
                    w = $urandom_range(2, 8);
                    h = $urandom_range(1, 6);
                end
            endcase
            case ($urandom_range(0, 7))
                0:       k = 0;
                1:       k = $urandom_range(9, 15);   // saturates to the widest window
                default: k = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 16'hFFFF;
                2:       thr = $urandom_range(0, 65535);
                default: thr = $urandom_range(0, 600);
            endcase

            // upper data bits beyond each register's width are sometimes set
            junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
            write_register(CFG_IMAGE_WIDTH,  16'(w) | (junk & 16'hFE00));
            write_register(CFG_IMAGE_HEIGHT, 16'(h) | (junk & 16'hFE00));
            write_register(CFG_WINDOW_HALF,  16'(k) | (junk & 16'hFFF0));
            write_register(CFG_THRESHOLD,    16'(thr));

            steady_sender = ($urandom_range(0, 3) == 0);
            style         = $urandom_range(0, 3);

            // frame load
            for (y = 0; y < h; y++)
            begin
                for (x = 0; x < w; x++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_stray(w, h);
                    case (style)
                        0:       shade = 8'($urandom);
                        1:       shade = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                        2:       shade = 8'(x * 17 + y * 9 + $urandom_range(0, 3));
                        default: shade = (2 * x >= w && 2 * y >= h) ? 8'd230 : 8'd20;
                    endcase
                    send_item(OP_WRITE, 8'(x), 8'(y), shade, 1'b0, RES_CLEAR, next_gap());
                end
            end

            // queries, with the odd rewrite and stray transaction
            n_q = $urandom_range(3, 10);
            repeat (n_q)
            begin
                pick = $urandom_range(0, 9);
                x    = $urandom_range(0, w - 1);
                y    = $urandom_range(0, h - 1);
                if (pick < 7)
                    send_item(OP_QUERY, 8'(x), 8'(y), 8'($urandom), 1'b0, RES_CLEAR,
                              next_gap());
                else if (pick == 7)
                    send_item(OP_WRITE, 8'(x), 8'(y), 8'($urandom), 1'b0, RES_CLEAR,
                              next_gap());
                else
                    send_stray(w, h);
            end
        end

        // drain, then give any late spurious strobe a chance to show
        wait_all_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fault_count == 0 && marking_due.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mipm_pkg.sv
rtl/core/mipm_ram.sv
rtl/core/moravec_interest_point_marker_core.sv
tb/tb_top.sv
